// ===== rtl/core/tqu_pkg.sv =====
// Shared types, constants and codes of the tabular Q-value update block.
`default_nettype none

package tqu_pkg;

  localparam int DEF_NUM_ACTIONS = 4;
  localparam int DEF_STATE_BITS  = 10;

  localparam int ACTION_W    = 2;
  localparam int REWARD_W    = 16;
  localparam int Q_W         = 32;
  localparam int RATE_W      = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISCOUNT_FACTOR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VALUE   = 2'd2;

  localparam logic [RATE_W-1:0] LEARNING_RATE_RST   = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_FACTOR_RST = 16'd58982;
  localparam logic [Q_W-1:0]    INITIAL_VALUE_RST   = 32'd0;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  // Length of the ST_CALC state, counted by calc_cnt, before the write-back.
  localparam int CALC_CYCLES = 4;
  localparam int CALC_CNT_W  = $clog2(CALC_CYCLES);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_NEXT,
    ST_NV_CHK,
    ST_NX_RD,
    ST_FILL_N,
    ST_CV_RD,
    ST_CV_CHK,
    ST_FILL_C,
    ST_CALC,
    ST_WB
  } tqu_state_t;

  typedef enum logic {
    ROW_NXT,
    ROW_CUR
  } row_sel_t;

  typedef enum logic [1:0] {
    BEST_HOLD,
    BEST_MIN,
    BEST_INIT,
    BEST_ZERO
  } best_src_t;

  typedef enum logic [1:0] {
    Q_HOLD,
    Q_RAM,
    Q_INIT
  } q_src_t;

  typedef struct packed {
    logic      load;
    logic      clr_step;
    logic      vld_rd;
    logic      vld_set;
    row_sel_t  row_sel;
    logic      q_rd;
    logic      q_rd_act;
    logic      best_track;
    logic      q_fill;
    logic      idx_clr;
    logic      idx_inc;
    best_src_t best_ld;
    q_src_t    q_ld;
    logic      wb;
  } tqu_cmd_t;

  typedef struct packed {
    logic done;
    logic vld;
    logic idx_last;
    logic clr_last;
  } tqu_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/tqu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tqu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/tqu_ctrl.sv =====
// Controller state machine that sequences the valid clear after reset, table reads, fills and the update.
`default_nettype none

module tqu_ctrl
  import tqu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output tqu_cmd_t      cmd,
  input  wire tqu_sts_t sts
);

  tqu_state_t            state_r, state_nxt;
  logic [CALC_CNT_W-1:0] calc_cnt_r, calc_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      calc_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      calc_cnt_r <= calc_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    busy         = 1'b1;
    calc_cnt_nxt = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_RD_NEXT;
        end
      end
      ST_RD_NEXT: begin
        if (sts.done) begin
          cmd.vld_rd   = 1'b1;
          cmd.row_sel  = ROW_CUR;
          cmd.q_rd     = 1'b1;
          cmd.q_rd_act = 1'b1;
          cmd.best_ld  = BEST_ZERO;
          state_nxt    = ST_CV_CHK;
        end else begin
          cmd.vld_rd  = 1'b1;
          cmd.row_sel = ROW_NXT;
          state_nxt   = ST_NV_CHK;
        end
      end
      ST_NV_CHK: begin
        cmd.row_sel = ROW_NXT;
        if (sts.vld) begin
          cmd.best_ld = BEST_MIN;
          state_nxt   = ST_NX_RD;
        end else begin
          cmd.vld_set = 1'b1;
          cmd.best_ld = BEST_INIT;
          state_nxt   = ST_FILL_N;
        end
      end
      ST_NX_RD: begin
        cmd.row_sel    = ROW_NXT;
        cmd.q_rd       = 1'b1;
        cmd.best_track = 1'b1;
        cmd.idx_inc    = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_CV_RD;
        end
      end
      ST_FILL_N: begin
        cmd.row_sel = ROW_NXT;
        cmd.q_fill  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_CV_RD;
        end
      end
      ST_CV_RD: begin
        cmd.vld_rd   = 1'b1;
        cmd.row_sel  = ROW_CUR;
        cmd.q_rd     = 1'b1;
        cmd.q_rd_act = 1'b1;
        cmd.idx_clr  = 1'b1;
        state_nxt    = ST_CV_CHK;
      end
      ST_CV_CHK: begin
        cmd.row_sel = ROW_CUR;
        if (sts.vld) begin
          cmd.q_ld  = Q_RAM;
          state_nxt = ST_CALC;
        end else begin
          cmd.vld_set = 1'b1;
          cmd.q_ld    = Q_INIT;
          state_nxt   = ST_FILL_C;
        end
      end
      ST_FILL_C: begin
        cmd.row_sel = ROW_CUR;
        cmd.q_fill  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        calc_cnt_nxt = calc_cnt_r + 1'b1;
        if (calc_cnt_r == CALC_CNT_W'(CALC_CYCLES - 1)) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tqu_dp.sv =====
// Datapath: Q table, row valid memory, configuration and update arithmetic.
`default_nettype none

module tqu_dp
  import tqu_pkg::*;
#(
  parameter int NUM_ACTIONS = DEF_NUM_ACTIONS,
  parameter int STATE_BITS  = DEF_STATE_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tqu_cmd_t                   cmd,
  output tqu_sts_t                        sts,
  input  wire logic [STATE_BITS-1:0]      in_current_state,
  input  wire logic [STATE_BITS-1:0]      in_next_state,
  input  wire logic [ACTION_W-1:0]        in_action,
  input  wire logic signed [REWARD_W-1:0] in_reward,
  input  wire logic                       in_is_done,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output logic signed [Q_W-1:0]           out_new_q
);

  localparam int AW     = $clog2(NUM_ACTIONS);
  localparam int QAW    = STATE_BITS + AW;
  localparam int ROWS   = 2 ** STATE_BITS;
  localparam int QDEPTH = 2 ** QAW;

  logic [STATE_BITS-1:0]      cur_r, nxt_r, clr_row_r;
  logic [AW-1:0]              act_r, act_in, idx_r;
  logic signed [REWARD_W-1:0] reward_r;
  logic                       done_r, trk_pend_r;
  logic [RATE_W-1:0]          lr_r, df_r;
  logic signed [Q_W-1:0]      init_r, best_r, best_nxt, q_r, q_nxt;
  logic signed [48:0]         prod1_r, sum1;
  logic signed [33:0]         target_r, rew_q;
  logic signed [34:0]         err_r;
  logic signed [51:0]         prod2_r, sum2;
  logic signed [35:0]         rnd2_r;
  logic signed [36:0]         res;
  logic signed [Q_W-1:0]      sat_q;
  logic                       out_valid_r;
  logic signed [Q_W-1:0]      out_new_q_r;

  logic [STATE_BITS-1:0] row;
  logic                  q_we, v_we, v_wdata, v_rdata;
  logic [QAW-1:0]        q_waddr, q_raddr;
  logic [Q_W-1:0]        q_wdata, q_rdata;
  logic [STATE_BITS-1:0] v_waddr;

  always_comb begin
    if (int'(in_action) >= NUM_ACTIONS) begin
      act_in = AW'(NUM_ACTIONS - 1);
    end else begin
      act_in = AW'(in_action);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r        <= LEARNING_RATE_RST;
      df_r        <= DISCOUNT_FACTOR_RST;
      init_r      <= INITIAL_VALUE_RST;
      clr_row_r   <= '0;
      idx_r       <= '0;
      trk_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE:   lr_r   <= cfg_wdata[RATE_W-1:0];
          REG_DISCOUNT_FACTOR: df_r   <= cfg_wdata[RATE_W-1:0];
          REG_INITIAL_VALUE:   init_r <= cfg_wdata[Q_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) begin
        clr_row_r <= clr_row_r + 1'b1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      trk_pend_r  <= cmd.best_track;
      out_valid_r <= cmd.wb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r    <= in_current_state;
      nxt_r    <= in_next_state;
      act_r    <= act_in;
      reward_r <= in_reward;
      done_r   <= in_is_done;
    end
    best_r <= best_nxt;
    q_r    <= q_nxt;
    if (cmd.wb) begin
      out_new_q_r <= sat_q;
    end
    prod1_r  <= $signed({1'b0, df_r}) * best_r;
    target_r <= {sum1[48], sum1[48:16]} + rew_q;
    err_r    <= {target_r[33], target_r} - {{3{q_r[Q_W-1]}}, q_r};
    prod2_r  <= $signed({1'b0, lr_r}) * err_r;
    rnd2_r   <= sum2[51:16];
  end

  always_comb begin
    best_nxt = best_r;
    case (cmd.best_ld)
      BEST_MIN:  best_nxt = Q_MIN;
      BEST_INIT: best_nxt = init_r;
      BEST_ZERO: best_nxt = '0;
      default: begin
        if (trk_pend_r && ($signed(q_rdata) > best_r)) begin
          best_nxt = $signed(q_rdata);
        end
      end
    endcase
  end

  always_comb begin
    q_nxt = q_r;
    case (cmd.q_ld)
      Q_RAM:   q_nxt = $signed(q_rdata);
      Q_INIT:  q_nxt = init_r;
      default: q_nxt = q_r;
    endcase
  end

  assign sum1  = prod1_r + 49'sd32768;
  assign rew_q = {{10{reward_r[REWARD_W-1]}}, reward_r, 8'b0};
  assign sum2  = prod2_r + 52'sd32768;
  assign res   = {{5{q_r[Q_W-1]}}, q_r} + {rnd2_r[35], rnd2_r};

  always_comb begin
    if (res[36:31] == 6'b000000 || res[36:31] == 6'b111111) begin
      sat_q = res[Q_W-1:0];
    end else if (res[36]) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = Q_MAX;
    end
  end

  assign row     = (cmd.row_sel == ROW_CUR) ? cur_r : nxt_r;
  assign q_raddr = {row, (cmd.q_rd_act ? act_r : idx_r)};
  assign q_we    = cmd.q_fill | cmd.wb;
  assign q_waddr = cmd.wb ? {cur_r, act_r} : {row, idx_r};
  assign q_wdata = cmd.wb ? sat_q : init_r;
  assign v_we    = cmd.clr_step | cmd.vld_set;
  assign v_waddr = cmd.clr_step ? clr_row_r : row;
  assign v_wdata = ~cmd.clr_step;

  tqu_ram #(
    .WIDTH (Q_W),
    .DEPTH (QDEPTH)
  ) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (cmd.q_rd),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  tqu_ram #(
    .WIDTH (1),
    .DEPTH (ROWS)
  ) u_vld_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (cmd.vld_rd),
    .raddr (row),
    .rdata (v_rdata)
  );

  assign sts.done     = done_r;
  assign sts.vld      = v_rdata;
  assign sts.idx_last = (idx_r == AW'(NUM_ACTIONS - 1));
  assign sts.clr_last = &clr_row_r;

  assign out_valid = out_valid_r;
  assign out_new_q = out_new_q_r;

endmodule

`default_nettype wire

// ===== rtl/core/tabular_q_value_update.sv =====
// Top level of the tabular Q-value update block.
// Time from an accepted start to the out_valid strobe is shorter when is_done is set, as the
// next row is then not read, and longer when the current row is touched first and is filled.
// The single Q memory port reading the next row one action per cycle and the five-register
// multiply chain set this; start is taken again in the strobe cycle. Results cannot be stalled.
// After reset the row valid memory is cleared, with busy held high.
`default_nettype none

module tabular_q_value_update
  import tqu_pkg::*;
#(
  parameter int NUM_ACTIONS = DEF_NUM_ACTIONS,
  parameter int STATE_BITS  = DEF_STATE_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [STATE_BITS-1:0]      in_current_state,
  input  wire logic [STATE_BITS-1:0]      in_next_state,
  input  wire logic [ACTION_W-1:0]        in_action,
  input  wire logic signed [REWARD_W-1:0] in_reward,
  input  wire logic                       in_is_done,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output logic signed [Q_W-1:0]           out_new_q
);

  tqu_cmd_t cmd;
  tqu_sts_t sts;

  tqu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  tqu_dp #(
    .NUM_ACTIONS (NUM_ACTIONS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_current_state (in_current_state),
    .in_next_state    (in_next_state),
    .in_action        (in_action),
    .in_reward        (in_reward),
    .in_is_done       (in_is_done),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_new_q        (out_new_q)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tqu_checker.sv =====
// Port-level checker for the tabular Q-value update block and its bind.
`default_nettype none

module tqu_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe lasted more than one cycle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not make the block busy.");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result strobe while the block is still busy.");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("Result strobe without a transaction in progress.");

  a_clear_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> busy)
    else $error("Block not busy clearing the table after reset.");

endmodule

bind tabular_q_value_update tqu_checker u_tqu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire
